/* hw/rtl/bmt_pkg.sv */
// Shared constants, types and register codes of the 3x3 box-mean threshold block.
package bmt_pkg;

   // Frame and pixel limits
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int PIX_W       = 8;
   localparam int MIN_SIZE    = 3;

   // Counter and size widths
   localparam int COL_W      = $clog2(MAX_COLUMNS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_SIZE_W = COL_W + 1;
   localparam int ROW_SIZE_W = ROW_W + 1;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int THR_W      = 8;
   localparam int THRESHOLD_RESET = 10;

   // Window arithmetic
   localparam int WINDOW_CELLS = 9;
   localparam int COLSUM_W     = PIX_W + 2;
   localparam int SUM_W        = PIX_W + 4;
   localparam int LIM_W        = THR_W + 4;
   localparam int CMP_W        = (SUM_W > LIM_W) ? SUM_W : LIM_W;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_COLUMNS  = 2'd0,
      CSR_FRAME_ROWS     = 2'd1,
      CSR_MEAN_THRESHOLD = 2'd2
   } csr_index_type;

   // Active configuration, sizes already clamped
   typedef struct packed {
      logic [COL_SIZE_W-1:0] cols;
      logic [ROW_SIZE_W-1:0] rows;
      logic [LIM_W-1:0]      limit;
   } cfg_type;

   // Raster position of one item and what its result carries
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             emit;
      logic             row_end;
      logic             frame_end;
   } pos_type;

endpackage

/* hw/rtl/box_mean_threshold_3x3.sv */
// Top level of the 3x3 box-mean threshold detector.
//
// Pixels enter in raster order, one item per clock while rsp_ready stays high; a
// pixel is taken whenever the first pipeline stage is free. While a result waits in
// the output register, the two stages behind it can still fill, and border pixels
// keep flowing past it, so the input stops only once both stages are held. Every
// pixel at column >= 2 and row >= 2 gives one result for the pixel one row up and
// one column left; border pixels give none. When a pixel is taken, the line
// memories are read; as it leaves stage 1 the column-sum window is updated, and
// as it leaves stage 2 the box sum and compare are loaded into the output
// register. No clearing pass is needed after reset. Frame size and threshold are
// to be written through the csr_ port only while the block is idle; the block
// itself does not enforce this. Sizes are clamped to 3 up to 1024.
module box_mean_threshold_3x3 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bmt_pkg::PIX_W-1:0]        req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_star,
   output logic                             rsp_row_end,
   output logic                             rsp_frame_end,
   input  logic                             csr_wr_en,
   input  logic [bmt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmt_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import bmt_pkg::*;

   cfg_type          cfg;
   pos_type          cur_pos;
   logic             accept;

   logic             s1_valid_ff;
   pos_type          s1_pos_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic             s2_valid_ff;
   pos_type          s2_pos_ff;
   logic             rsp_valid_ff;
   logic             rsp_star_ff;
   logic             rsp_row_end_ff;
   logic             rsp_frame_end_ff;

   logic             out_free;
   logic             s2_move;
   logic             s2_free;
   logic             s1_move;
   logic             s1_free;
   logic             win_star;
   logic [PIX_W-1:0] top_pixel;
   logic [PIX_W-1:0] mid_pixel;

   bmt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   bmt_raster_ctr u_raster_ctr (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cfg     (cfg),
      .pos     (cur_pos)
   );

   // Stage flow: each stage moves when the next one is free or moves too; border items leave stage 2 without waiting
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && (!s2_pos_ff.emit || out_free);
   assign s2_free   = !s2_valid_ff || s2_move;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;

   bmt_line_store u_line_store (
      .clock       (clock),
      .rd_en       (accept),
      .rd_addr     (cur_pos.col),
      .mid_wr_data (req_pixel),
      .up_wr_en    (s1_move),
      .up_wr_addr  (s1_pos_ff.col),
      .up_wr_data  (mid_pixel),
      .top_pixel   (top_pixel),
      .mid_pixel   (mid_pixel)
   );

   bmt_window u_window (
      .clock     (clock),
      .shift_en  (s1_move),
      .top_pixel (top_pixel),
      .mid_pixel (mid_pixel),
      .new_pixel (s1_pixel_ff),
      .limit     (cfg.limit),
      .star      (win_star)
   );

   // Stage 1: item waits for its line memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff   <= cur_pos;
         s1_pixel_ff <= req_pixel;
      end
   end

   // Stage 2: window holds the columns up to this item
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_move;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_pos_ff <= s1_pos_ff;
      end
   end

   // Output register: load interior results, drop border items
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_move && s2_pos_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move && s2_pos_ff.emit) begin
         rsp_star_ff      <= win_star;
         rsp_row_end_ff   <= s2_pos_ff.row_end;
         rsp_frame_end_ff <= s2_pos_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_star      = rsp_star_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

`ifndef SYNTHESIS
   // A frame end is always also a row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_frame_end_ff || rsp_row_end_ff))
      else $error("frame end without row end");

   // Upper line write-back never collides with the read of a new item
   assert property (@(posedge clock) disable iff (reset)
      (s1_move && accept) |-> (s1_pos_ff.col != cur_pos.col))
      else $error("line store write-back hits the column being read");

   // The item right after a row end starts at column zero, checked when both are accepted back to back
   assert property (@(posedge clock) disable iff (reset)
      (accept && $past(accept && cur_pos.row_end)) |-> (cur_pos.col == '0))
      else $error("row did not restart at column zero");
`endif

endmodule

/* hw/rtl/bmt_csr.sv */
// Configuration registers: frame size with clamping and the star sum limit.
module bmt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bmt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmt_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output bmt_pkg::cfg_type                 cfg
);
   import bmt_pkg::*;

   logic [COL_SIZE_W-1:0] cols_ff;
   logic [ROW_SIZE_W-1:0] rows_ff;
   logic [LIM_W-1:0]      limit_ff;
   logic [COL_SIZE_W-1:0] cols_in;
   logic [ROW_SIZE_W-1:0] rows_in;
   logic [LIM_W-1:0]      limit_in;

   // Clamp sizes into the supported range
   always_comb begin
      if (csr_wr_data < CSR_DATA_W'(MIN_SIZE)) begin
         cols_in = COL_SIZE_W'(MIN_SIZE);
         rows_in = ROW_SIZE_W'(MIN_SIZE);
      end else begin
         cols_in = (32'(csr_wr_data) > 32'(MAX_COLUMNS)) ?
                   COL_SIZE_W'(MAX_COLUMNS) : COL_SIZE_W'(csr_wr_data);
         rows_in = (32'(csr_wr_data) > 32'(MAX_ROWS)) ?
                   ROW_SIZE_W'(MAX_ROWS) : ROW_SIZE_W'(csr_wr_data);
      end
   end

   // floor(sum/9) > t  is the same as  sum >= 9*(t+1)
   assign limit_in = LIM_W'(csr_wr_data[THR_W-1:0]) * LIM_W'(WINDOW_CELLS)
                   + LIM_W'(WINDOW_CELLS);

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COL_SIZE_W'(MAX_COLUMNS);
         rows_ff  <= ROW_SIZE_W'(MAX_ROWS);
         limit_ff <= LIM_W'(WINDOW_CELLS * (THRESHOLD_RESET + 1));
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_COLUMNS:  cols_ff  <= cols_in;
            CSR_FRAME_ROWS:     rows_ff  <= rows_in;
            CSR_MEAN_THRESHOLD: limit_ff <= limit_in;
            default: ;
         endcase
      end
   end

   assign cfg.cols  = cols_ff;
   assign cfg.rows  = rows_ff;
   assign cfg.limit = limit_ff;

endmodule

/* hw/rtl/bmt_raster_ctr.sv */
// Column and row counters that place each incoming item in the frame.
module bmt_raster_ctr (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  bmt_pkg::cfg_type   cfg,
   output bmt_pkg::pos_type   pos
);
   import bmt_pkg::*;

   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic                  wrap_pre;
   logic [ROW_SIZE_W-1:0] row_tmp;
   logic [COL_W-1:0]      col_cur;
   logic [ROW_W-1:0]      row_cur;
   logic [COL_SIZE_W-1:0] col_inc;
   logic [ROW_SIZE_W-1:0] row_inc;
   logic                  last_col;
   logic                  last_row;

   // Wrap a counter left past a smaller size before using it
   assign wrap_pre = {1'b0, col_ff} >= cfg.cols;
   assign row_tmp  = wrap_pre ? ({1'b0, row_ff} + ROW_SIZE_W'(1)) : {1'b0, row_ff};
   assign col_cur  = wrap_pre ? '0 : col_ff;
   assign row_cur  = (row_tmp >= cfg.rows) ? '0 : row_tmp[ROW_W-1:0];

   // Position of the next item
   assign col_inc  = {1'b0, col_cur} + COL_SIZE_W'(1);
   assign row_inc  = {1'b0, row_cur} + ROW_SIZE_W'(1);
   assign last_col = col_inc >= cfg.cols;
   assign last_row = row_inc >= cfg.rows;

   always_comb begin
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = row_cur;
      end
   end

   // Advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign pos.col       = col_cur;
   assign pos.emit      = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
   assign pos.row_end   = last_col;
   assign pos.frame_end = last_col && last_row;

endmodule

/* hw/rtl/bmt_line_store.sv */
// Two line memories holding the two rows above the current pixel.
module bmt_line_store (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [bmt_pkg::COL_W-1:0]  rd_addr,
   input  logic [bmt_pkg::PIX_W-1:0]  mid_wr_data,
   input  logic                       up_wr_en,
   input  logic [bmt_pkg::COL_W-1:0]  up_wr_addr,
   input  logic [bmt_pkg::PIX_W-1:0]  up_wr_data,
   output logic [bmt_pkg::PIX_W-1:0]  top_pixel,
   output logic [bmt_pkg::PIX_W-1:0]  mid_pixel
);
   import bmt_pkg::*;

   logic [PIX_W-1:0] upper_mem  [MAX_COLUMNS];
   logic [PIX_W-1:0] middle_mem [MAX_COLUMNS];
   logic [PIX_W-1:0] top_ff;
   logic [PIX_W-1:0] mid_ff;

   // Upper row: read for the new item, write back the old middle row later
   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_ff <= upper_mem[rd_addr];
      end
      if (up_wr_en) begin
         upper_mem[up_wr_addr] <= up_wr_data;
      end
   end

   // Middle row: read old value and store the new pixel at the same column
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mid_ff              <= middle_mem[rd_addr];
         middle_mem[rd_addr] <= mid_wr_data;
      end
   end

   assign top_pixel = top_ff;
   assign mid_pixel = mid_ff;

endmodule

/* hw/rtl/bmt_window.sv */
// 3x3 window kept as three column sums, with the threshold compare.
module bmt_window (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic [bmt_pkg::PIX_W-1:0]  top_pixel,
   input  logic [bmt_pkg::PIX_W-1:0]  mid_pixel,
   input  logic [bmt_pkg::PIX_W-1:0]  new_pixel,
   input  logic [bmt_pkg::LIM_W-1:0]  limit,
   output logic                       star
);
   import bmt_pkg::*;

   logic [COLSUM_W-1:0] colsum_ff [3];
   logic [COLSUM_W-1:0] colsum_in;
   logic [SUM_W-1:0]    box_sum;

   // Sum the newest column
   assign colsum_in = COLSUM_W'(top_pixel) + COLSUM_W'(mid_pixel) + COLSUM_W'(new_pixel);

   // Shift columns left, newest on the right
   always_ff @(posedge clock) begin
      if (shift_en) begin
         colsum_ff[0] <= colsum_ff[1];
         colsum_ff[1] <= colsum_ff[2];
         colsum_ff[2] <= colsum_in;
      end
   end

   // Compare the full box sum against the limit
   assign box_sum = SUM_W'(colsum_ff[0]) + SUM_W'(colsum_ff[1]) + SUM_W'(colsum_ff[2]);
   assign star    = CMP_W'(box_sum) >= CMP_W'(limit);

endmodule
